### design/rth_pkg.sv
package rth_pkg;

    localparam int HUE_FRAC_BITS = 6;

    localparam int BYTE_W = 8;
    localparam int HUE_W  = 15;
    localparam int SAT_W  = 16;

    // divisors are 2*max or 2*delta, both below 2^9
    localparam int DIV_W  = BYTE_W + 1;

    // saturation: (delta*2^16 + max) / (2*max), quotient at most 2^15
    localparam int SAT_QB = 16;

    // hue: (num*2^(F+1) + delta) / (2*delta), num below 360*delta
    localparam int NUM_W      = 17;
    localparam int HUE_QB     = 9 + HUE_FRAC_BITS;
    localparam int HUE_DVD_W  = NUM_W + HUE_FRAC_BITS + 1;
    localparam int HUE_FULL   = 360 << HUE_FRAC_BITS;

    localparam int PIPE_DEPTH = (SAT_QB > HUE_QB) ? SAT_QB : HUE_QB;

    // cycles from the accepting edge to the edge that samples the result strobe
    localparam int LATENCY    = PIPE_DEPTH + 3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef struct packed {
        logic [BYTE_W-1:0] red_in;
        logic [BYTE_W-1:0] green_in;
        logic [BYTE_W-1:0] blue_in;
        logic [BYTE_W-1:0] alpha_in;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue_out;
        logic [SAT_W-1:0]  saturation_out;
        logic [BYTE_W-1:0] value_out;
        logic [BYTE_W-1:0] alpha_out;
    } hsv_t;

    // one classified item: two restoring divisions in flight plus passthrough bytes
    typedef struct packed {
        logic [DIV_W-1:0]  sat_rem;
        logic [SAT_QB-1:0] sat_quo;
        logic [DIV_W-1:0]  sat_div;
        logic [DIV_W-1:0]  hue_rem;
        logic [HUE_QB-1:0] hue_quo;
        logic [DIV_W-1:0]  hue_div;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] alpha;
    } work_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

endpackage

### design/rth_front.sv
module rth_front (
    input  logic            start,
    input  rth_pkg::pixel_t pixel,
    input  logic            full,
    output logic            push,
    output rth_pkg::work_t  work
);

    localparam int SW = rth_pkg::NUM_W + 2;

    logic [rth_pkg::BYTE_W-1:0]    r;
    logic [rth_pkg::BYTE_W-1:0]    g;
    logic [rth_pkg::BYTE_W-1:0]    b;
    logic [rth_pkg::BYTE_W-1:0]    mx;
    logic [rth_pkg::BYTE_W-1:0]    mn;
    logic [rth_pkg::BYTE_W-1:0]    delta;
    logic signed [rth_pkg::BYTE_W:0] diff;
    logic signed [SW-1:0]          num_s;
    logic [rth_pkg::NUM_W-1:0]     num;
    logic [rth_pkg::HUE_DVD_W-1:0] hue_dvd;

    assign push = start && !full;

    always_comb
    begin
        r = pixel.red_in;
        g = pixel.green_in;
        b = pixel.blue_in;

        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        delta = mx - mn;

        // sector select, red wins ties, then green
        if (r >= g && r >= b)
        begin
            diff  = $signed({1'b0, g}) - $signed({1'b0, b});
            num_s = SW'(diff) * SW'(60);
            if (g < b)
            begin
                num_s = num_s + SW'(delta) * SW'(360);
            end
        end
        else if (g >= b)
        begin
            diff  = $signed({1'b0, b}) - $signed({1'b0, r});
            num_s = SW'(delta) * SW'(120) + SW'(diff) * SW'(60);
        end
        else
        begin
            diff  = $signed({1'b0, r}) - $signed({1'b0, g});
            num_s = SW'(delta) * SW'(240) + SW'(diff) * SW'(60);
        end
        num = rth_pkg::NUM_W'(num_s);

        hue_dvd = (rth_pkg::HUE_DVD_W'(num) << (rth_pkg::HUE_FRAC_BITS + 1))
                + rth_pkg::HUE_DVD_W'(delta);

        // saturation dividend delta*2^16 + max: top part is delta, low part is max
        work.sat_rem = rth_pkg::DIV_W'(delta);
        work.sat_quo = rth_pkg::SAT_QB'(mx);
        work.sat_div = (mx == '0) ? rth_pkg::DIV_W'(1) : {mx, 1'b0};

        // grey or black: zero dividend over one gives zero hue
        if (delta == '0)
        begin
            work.hue_rem = '0;
            work.hue_quo = '0;
            work.hue_div = rth_pkg::DIV_W'(1);
        end
        else
        begin
            work.hue_rem = hue_dvd[rth_pkg::HUE_DVD_W-1:rth_pkg::HUE_QB];
            work.hue_quo = hue_dvd[rth_pkg::HUE_QB-1:0];
            work.hue_div = {delta, 1'b0};
        end

        work.value = mx;
        work.alpha = pixel.alpha_in;
    end

endmodule

### design/rth_fifo.sv
module rth_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rth_pkg::work_t        wdata,
    input  logic                  pop,
    output rth_pkg::work_t        rdata,
    output rth_pkg::fifo_status_t status
);

    rth_pkg::work_t               mem_reg [rth_pkg::FIFO_DEPTH];
    logic [rth_pkg::FIFO_AW-1:0]  wr_ptr_reg;
    logic [rth_pkg::FIFO_AW-1:0]  rd_ptr_reg;
    logic [rth_pkg::FIFO_CW-1:0]  count_reg;
    logic [rth_pkg::FIFO_CW-1:0]  count_next;
    logic                         do_push;
    logic                         do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == rth_pkg::FIFO_CW'(rth_pkg::FIFO_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### design/rth_back.sv
module rth_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  rth_pkg::work_t item,
    output logic           done,
    output rth_pkg::hsv_t  hsv
);

    localparam int D = rth_pkg::PIPE_DEPTH;
    localparam int W = rth_pkg::DIV_W;

    logic           valid_reg [D+1];
    rth_pkg::work_t stage_reg [D+1];
    logic           done_reg;
    rth_pkg::hsv_t  hsv_reg;
    rth_pkg::hsv_t  hsv_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg[0] <= item;
    end

    // one quotient bit of each division per stage, while that division still has quotient bits left
    for (genvar k = 0; k < D; k++)
    begin : g_stage
        rth_pkg::work_t cur;
        rth_pkg::work_t nxt;
        logic [W:0]     s_sh;
        logic [W+1:0]   s_trial;
        logic [W:0]     h_sh;
        logic [W+1:0]   h_trial;

        assign cur = stage_reg[k];

        always_comb
        begin
            nxt     = cur;
            s_sh    = {cur.sat_rem, cur.sat_quo[rth_pkg::SAT_QB-1]};
            s_trial = {1'b0, s_sh} - {2'b00, cur.sat_div};
            h_sh    = {cur.hue_rem, cur.hue_quo[rth_pkg::HUE_QB-1]};
            h_trial = {1'b0, h_sh} - {2'b00, cur.hue_div};
            if (k < rth_pkg::SAT_QB)
            begin
                nxt.sat_rem = s_trial[W+1] ? s_sh[W-1:0] : s_trial[W-1:0];
                nxt.sat_quo = {cur.sat_quo[rth_pkg::SAT_QB-2:0], !s_trial[W+1]};
            end
            if (k < rth_pkg::HUE_QB)
            begin
                nxt.hue_rem = h_trial[W+1] ? h_sh[W-1:0] : h_trial[W-1:0];
                nxt.hue_quo = {cur.hue_quo[rth_pkg::HUE_QB-2:0], !h_trial[W+1]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            stage_reg[k+1] <= nxt;
        end
    end

    always_comb
    begin
        hsv_next.hue_out = rth_pkg::HUE_W'(stage_reg[D].hue_quo);
        // a hue that rounds up to a full turn wraps to zero
        if (stage_reg[D].hue_quo >= rth_pkg::HUE_QB'(rth_pkg::HUE_FULL))
        begin
            hsv_next.hue_out = '0;
        end
        hsv_next.saturation_out = rth_pkg::SAT_W'(stage_reg[D].sat_quo);
        hsv_next.value_out      = stage_reg[D].value;
        hsv_next.alpha_out      = stage_reg[D].alpha;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[D];
        end
    end

    always_ff @(posedge clk)
    begin
        hsv_reg <= hsv_next;
    end

    assign done = done_reg;
    assign hsv  = hsv_reg;

endmodule

### design/rgb_to_hsv_converter_top.sv
// RGBA to HSV converter. Raise start with a pixel while busy is low and the pixel is taken
// at that edge; one pixel can be taken every clock. Each item comes back as one hsv result
// on the cycle that done is high, after a 4-entry queue write, an input register, a 16-stage
// divider pipeline that retires one saturation quotient bit per stage and one hue quotient
// bit per stage but the last, and an output register. Results appear for exactly one cycle
// and cannot be held off, so capture them when done is high. Value is the largest color byte,
// alpha passes through, saturation is Q1.15 (32768 is 1.0) and hue is in 1/64 degree, both
// rounded to nearest. Because the pipeline never stalls, busy stays low in normal use.
module rgb_to_hsv_converter_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  rth_pkg::pixel_t pixel,
    output logic            done,
    output rth_pkg::hsv_t   hsv
);

    rth_pkg::work_t        front_work;
    rth_pkg::work_t        queue_head;
    rth_pkg::fifo_status_t queue_status;
    logic                  front_push;

    // front: pick the max sector, form the dividends and divisors
    rth_front u_front (
        .start (start),
        .pixel (pixel),
        .full  (queue_status.full),
        .push  (front_push),
        .work  (front_work)
    );

    // short queue between classification and division
    rth_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (front_push),
        .wdata  (front_work),
        .pop    (!queue_status.empty),
        .rdata  (queue_head),
        .status (queue_status)
    );

    // back: drain the queue every cycle into the divider pipeline
    rth_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (!queue_status.empty),
        .item       (queue_head),
        .done       (done),
        .hsv        (hsv)
    );

    assign busy = queue_status.full;

endmodule

### design/rth_checker.sv
module rth_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input rth_pkg::pixel_t pixel,
    input logic            done,
    input rth_pkg::hsv_t   hsv
);

    // every accepted item comes back after the fixed latency with its alpha
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(rth_pkg::LATENCY)
            (done && hsv.alpha_out == $past(pixel.alpha_in, rth_pkg::LATENCY)))
        else $error("accepted item did not return on time");

    // no result without an item taken the latency earlier
    assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##(rth_pkg::LATENCY) !done)
        else $error("result without an accepted item");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hsv.saturation_out <= 16'd32768
                  && hsv.hue_out < rth_pkg::HUE_W'(rth_pkg::HUE_FULL)))
        else $error("hue or saturation out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && hsv.value_out == '0) |-> (hsv.hue_out == '0 && hsv.saturation_out == '0))
        else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_converter_top rth_checker u_rth_checker (.*);

### bench/tb_rgb_to_hsv_converter_top.sv
module tb_rgb_to_hsv_converter_top;

    // Long enough to cover the widest input gap plus the pipeline drain, several times over.
    localparam int WATCHDOG_LIMIT = 600;
    localparam int MAX_REPORTS    = 10;

    // Shapes of random pixels; anything past uniform aims at corners of the hue and
    // saturation math.
    typedef enum int {
        MIX_UNIFORM = 0,
        MIX_GREY    = 1,
        MIX_TIE     = 2,
        MIX_DARK    = 3,
        MIX_EDGE    = 4,
        MIX_NARROW  = 5
    } pixel_mix_t;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            start;
    logic            busy;
    rth_pkg::pixel_t pixel;
    logic            done;
    rth_pkg::hsv_t   hsv;

    // Predicted results, oldest first, in the order the pixels were taken.
    rth_pkg::hsv_t pending_hsv[$];

    int gap_odds;
    int pixels_sent;
    int directed_sent;
    int results_checked;
    int mismatch_count;
    int stray_results;
    int report_count;
    int quiet_cycles;
    int grey_seen;
    int red_max_seen;
    int green_max_seen;
    int blue_max_seen;

    logic [7:0] edge_bytes [4] = '{8'h00, 8'h01, 8'hFE, 8'hFF};

    rgb_to_hsv_converter_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .pixel (pixel),
        .done  (done),
        .hsv   (hsv)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Compute the exact hexcone conversion in wide integers, then round and fit the
    // result into the port widths.
    function automatic rth_pkg::hsv_t predict_hsv(input rth_pkg::pixel_t p);
        longint unsigned r, g, b, top, bottom, spread;
        longint unsigned deg_num, hue_q, sat_q, one_deg;
        rth_pkg::hsv_t h;
        r = 64'(p.red_in);
        g = 64'(p.green_in);
        b = 64'(p.blue_in);
        top = r;
        if (g > top) top = g;
        if (b > top) top = b;
        bottom = r;
        if (g < bottom) bottom = g;
        if (b < bottom) bottom = b;
        spread = top - bottom;
        hue_q = 0;
        sat_q = 0;
        one_deg = 64'd1 << rth_pkg::HUE_FRAC_BITS;
        // black keeps hue and saturation at zero
        if (top != 0)
        begin
            sat_q = (spread * 65536 + top) / (2 * top);
            // grey keeps hue at zero
            if (spread != 0)
            begin
                // red wins ties, then green; a negative red-sector hue wraps by 360 degrees
                if (top == r)
                    deg_num = (g >= b) ? 60 * (g - b) : 360 * spread - 60 * (b - g);
                else if (top == g)
                    deg_num = 120 * spread + 60 * b - 60 * r;
                else
                    deg_num = 240 * spread + 60 * r - 60 * g;
                hue_q = (2 * deg_num * one_deg + spread) / (2 * spread);
                if (hue_q >= 360 * one_deg)
                    hue_q = 0;
            end
        end
        h.hue_out        = hue_q[rth_pkg::HUE_W-1:0];
        h.saturation_out = sat_q[rth_pkg::SAT_W-1:0];
        h.value_out      = top[rth_pkg::BYTE_W-1:0];
        h.alpha_out      = p.alpha_in;
        return h;
    endfunction

    function automatic rth_pkg::pixel_t random_pixel();
        pixel_mix_t mix;
        int pick;
        logic [7:0] peak, other;
        rth_pkg::pixel_t p;
        pick = $urandom_range(0, 9);
        mix = (pick >= 5) ? pixel_mix_t'(pick - 4) : MIX_UNIFORM;
        p.red_in   = 8'($urandom);
        p.green_in = 8'($urandom);
        p.blue_in  = 8'($urandom);
        p.alpha_in = 8'($urandom);
        case (mix)
            MIX_GREY:
            begin
                p.green_in = p.red_in;
                p.blue_in  = p.red_in;
            end
            MIX_TIE:
            begin
                peak  = 8'($urandom);
                other = 8'($urandom_range(0, peak));
                case ($urandom_range(0, 2))
                    0:
                    begin
                        p.red_in   = peak;
                        p.green_in = peak;
                        p.blue_in  = other;
                    end
                    1:
                    begin
                        p.red_in   = peak;
                        p.green_in = other;
                        p.blue_in  = peak;
                    end
                    default:
                    begin
                        p.red_in   = other;
                        p.green_in = peak;
                        p.blue_in  = peak;
                    end
                endcase
            end
            MIX_DARK:
            begin
                p.red_in   = 8'($urandom_range(0, 3));
                p.green_in = 8'($urandom_range(0, 3));
                p.blue_in  = 8'($urandom_range(0, 3));
            end
            MIX_EDGE:
            begin
                p.red_in   = edge_bytes[2'($urandom_range(0, 3))];
                p.green_in = edge_bytes[2'($urandom_range(0, 3))];
                p.blue_in  = edge_bytes[2'($urandom_range(0, 3))];
            end
            MIX_NARROW:
            begin
                peak       = 8'($urandom_range(1, 255));
                p.red_in   = peak - 8'($urandom_range(0, 1));
                p.green_in = peak - 8'($urandom_range(0, 1));
                p.blue_in  = peak - 8'($urandom_range(0, 1));
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    // Offer one pixel and hold it until the block takes it, then maybe leave a gap
    // with noise on the pixel bus.
    task automatic send_rgba(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] a);
        rth_pkg::pixel_t p;
        p.red_in   = r;
        p.green_in = g;
        p.blue_in  = b;
        p.alpha_in = a;
        start <= 1'b1;
        pixel <= p;
        do
            @(posedge clk);
        while (busy);
        pixels_sent++;
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
        begin
            start <= 1'b0;
            pixel <= rth_pkg::pixel_t'($urandom);
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic test_extremes();
        gap_odds = 3;
        send_rgba(8'h00, 8'h00, 8'h00, 8'h00);
        send_rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_rgba(8'h00, 8'h00, 8'h00, 8'hFF);
        send_rgba(8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_rgba(8'h80, 8'h80, 8'h80, 8'h55);
        send_rgba(8'h01, 8'h01, 8'h01, 8'hAA);
    endtask

    task automatic test_hue_sectors();
        send_rgba(8'hFF, 8'h00, 8'h00, 8'h12);
        send_rgba(8'h00, 8'hFF, 8'h00, 8'h34);
        send_rgba(8'h00, 8'h00, 8'hFF, 8'h56);
        // ties for the largest channel, then mixed hues with no tie
        send_rgba(8'hFF, 8'hFF, 8'h00, 8'h78);
        send_rgba(8'h00, 8'hFF, 8'hFF, 8'h9A);
        send_rgba(8'hFF, 8'h00, 8'hFF, 8'hBC);
        send_rgba(8'hFF, 8'h80, 8'h00, 8'hDE);
        send_rgba(8'h00, 8'h80, 8'hFF, 8'hF0);
        send_rgba(8'h80, 8'h00, 8'hFF, 8'h0F);
    endtask

    task automatic test_special_cases();
        // red sector with blue above green wraps back below 360 degrees
        send_rgba(8'hFF, 8'h00, 8'h01, 8'h01);
        send_rgba(8'hC8, 8'h0A, 8'h0B, 8'h02);
        send_rgba(8'h01, 8'h00, 8'h01, 8'h04);
        // smallest spreads and rounding of saturation
        send_rgba(8'h01, 8'h00, 8'h00, 8'h08);
        send_rgba(8'hFF, 8'hFE, 8'hFE, 8'h10);
        send_rgba(8'h02, 8'h01, 8'h01, 8'h20);
    endtask

    // Pick the gap rate at random per block so that long gap-free stretches mix with gappy ones.
    task automatic test_random_pixels();
        rth_pkg::pixel_t p;
        directed_sent = pixels_sent;
        for (int blk = 0; blk < 25; blk++)
        begin
            case ($urandom_range(0, 2))
                0: gap_odds = 0;
                1: gap_odds = 2;
                default: gap_odds = 8;
            endcase
            repeat (50)
            begin
                p = random_pixel();
                send_rgba(p.red_in, p.green_in, p.blue_in, p.alpha_in);
            end
        end
    endtask

    task automatic test_back_to_back();
        rth_pkg::pixel_t p;
        gap_odds = 0;
        repeat (180)
        begin
            p = random_pixel();
            send_rgba(p.red_in, p.green_in, p.blue_in, p.alpha_in);
        end
    endtask

    // Check results first, then record the pixel taken at the same edge, so ordering
    // inside one edge never matters.
    always @(posedge clk)
    begin : hsv_monitor
        rth_pkg::hsv_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_hsv.size() == 0)
                begin
                    stray_results++;
                    if (report_count < MAX_REPORTS)
                        $display("ERROR: result with nothing pending: %s %0d %0d %0d %0d",
                                 "hue/sat/val/a", hsv.hue_out, hsv.saturation_out,
                                 hsv.value_out, hsv.alpha_out);
                    report_count++;
                end
                else
                begin
                    want = pending_hsv.pop_front();
                    results_checked++;
                    if (hsv.hue_out !== want.hue_out ||
                        hsv.saturation_out !== want.saturation_out ||
                        hsv.value_out !== want.value_out ||
                        hsv.alpha_out !== want.alpha_out)
                    begin
                        mismatch_count++;
                        if (report_count < MAX_REPORTS)
                            $display({"ERROR: result %0d exp hue %0d sat %0d val %0d a %0d,",
                                      " got hue %0d sat %0d val %0d a %0d"},
                                     results_checked, want.hue_out, want.saturation_out,
                                     want.value_out, want.alpha_out, hsv.hue_out,
                                     hsv.saturation_out, hsv.value_out, hsv.alpha_out);
                        report_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                pending_hsv = {pending_hsv, predict_hsv(pixel)};
                if (pixel.red_in == pixel.green_in && pixel.green_in == pixel.blue_in)
                    grey_seen++;
                else if (pixel.red_in >= pixel.green_in && pixel.red_in >= pixel.blue_in)
                    red_max_seen++;
                else if (pixel.green_in >= pixel.blue_in)
                    green_max_seen++;
                else
                    blue_max_seen++;
            end
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stop a run that has gone silent for too long.
    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int failures;
        rst_n = 1'b0;
        start <= 1'b0;
        pixel <= '0;
        quiet_cycles = 0;
        gap_odds = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_hue_sectors();
        test_special_cases();
        test_random_pixels();
        test_back_to_back();
        start <= 1'b0;

        // Drain the pipeline, then watch a little longer for stray results.
        while (pending_hsv.size() != 0)
            @(posedge clk);
        repeat (rth_pkg::LATENCY + 8) @(posedge clk);

        failures = mismatch_count + stray_results + pending_hsv.size();
        $display("Sent %0d pixels (%0d directed), random gaps of 1 to 19 cycles, gap-free tail",
                 pixels_sent, directed_sent);
        $display("Checked %0d results: grey %0d, red max %0d, green max %0d, blue max %0d",
                 results_checked, grey_seen, red_max_seen, green_max_seen, blue_max_seen);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
